// File: design/tpida_pkg.sv
// Shared constants for the two-pool next-fit ID allocator.
// Field widths, result status codes, opcodes and configuration register indexes.
// Stand-alone package with no dependencies.
`default_nettype none

package tpida_pkg;

    localparam int SLOTS_PER_POOL_DEF = 256;
    localparam int POOLS              = 2;
    localparam int MARK_WORD_MAX      = 32;

    localparam int SIZE_W      = 9;
    localparam int BASE_W      = 16;
    localparam int HANDLE_W    = 32;
    localparam int ID_W        = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_DATA_W   = 56;
    localparam int OUT_DATA_W  = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [BASE_W-1:0] BASE_RESET = 16'd15000;
    localparam logic [ID_W-1:0]   RELEASE_ID_NONE = 16'hFFFF;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL0_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL1_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL1_BASE = 2'd2;

endpackage

`default_nettype wire

// File: design/two_pool_next_fit_id_allocator_top.sv
// Two-pool next-fit ID allocator, top level.
// Holds the slot mark memory, the owner handle memory and the sequencer; uses tpida_pkg.
`default_nettype none

// Use:
//   Input words arrive on s_axis_*; s_axis_tuser carries the opcode (allocate or
//   free), s_axis_tdata the pool select, owner handle and release ID. Every input
//   word produces exactly one result word on m_axis_*.
//   Configuration (pool sizes, base ID of pool one) goes through cfg_we / cfg_index /
//   cfg_data; the user must write it only while the block is idle, which the block itself does not enforce.
// Sequencing:
//   Slot marks sit in a memory of up to 32-bit rows; one shared find-first unit
//   examines one row at a time, first reading it (ST_SCAN_WAIT), then checking it
//   (ST_SCAN_CHK); a miss moves on to the next row, wrapping once to row zero.
//   A free reads its mark row and owner cell (ST_FREE_WAIT), then checks the mark (ST_FREE_CHK).
//   A full pool or an out-of-range free goes straight to ST_FINISH without a memory read.
//   The block takes one word at a time: s_axis_tready is high only when idle.
// Reset:
//   After reset a clearing pass zeroes the mark memory one row per cycle with
//   s_axis_tready low; configuration writes are accepted during the pass.
// Back pressure:
//   Results sit in an output register; a new word is accepted while a result
//   waits, and the next result is held back until the receiver drains it.

module two_pool_next_fit_id_allocator_top #(
    parameter int SLOTS_PER_POOL = tpida_pkg::SLOTS_PER_POOL_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration write port
    input  wire                                  cfg_we,
    input  wire  [tpida_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [tpida_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input words
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata from bit 0: pool_select(1), owner_handle(32), release_id(16), zero fill(7)
    input  wire  [tpida_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: opcode(1)
    input  wire  [0:0]                           s_axis_tuser,
    // result words
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // tdata from bit 0: status(2), assigned_id(16), freed_handle(32), pool_count(9),
    // zero fill(5)
    output logic [tpida_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import tpida_pkg::*;

    localparam int S    = SLOTS_PER_POOL;
    localparam int SW   = $clog2(S);                       // slot index width
    localparam int ESW  = $clog2(S + 1);                   // size / count width
    localparam int LMW  = (S >= MARK_WORD_MAX) ? $clog2(MARK_WORD_MAX) : SW;
    localparam int MW   = 1 << LMW;                        // marks per row
    localparam int RPP  = (S + MW - 1) / MW;               // rows per pool
    localparam int RW   = (RPP > 1) ? $clog2(RPP) : 1;
    localparam int ROWS = POOLS * RPP;
    localparam int RAW  = $clog2(ROWS);
    localparam int OAW  = $clog2(POOLS * S);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_WAIT,
        ST_SCAN_CHK,
        ST_FREE_WAIT,
        ST_FREE_CHK,
        ST_FINISH
    } state_t;

    // storage
    logic [MW-1:0]       mark_mem [ROWS];
    logic [HANDLE_W-1:0] owner_mem [POOLS*S];

    // control state
    state_t              state_reg, state_next;
    logic [RAW-1:0]      clr_row_reg, clr_row_next;
    logic [SIZE_W-1:0]   pool0_size_reg, pool0_size_next;
    logic [SIZE_W-1:0]   pool1_size_reg, pool1_size_next;
    logic [BASE_W-1:0]   pool1_base_reg, pool1_base_next;
    logic [ESW-1:0]      count_reg [POOLS];
    logic [ESW-1:0]      count_next [POOLS];
    logic [SW-1:0]       scan_pos_reg [POOLS];
    logic [SW-1:0]       scan_pos_next [POOLS];
    logic                pool_reg, pool_next;
    logic                wrapped_reg, wrapped_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [RW-1:0]       row0_reg, row0_next;
    logic [RW-1:0]       last_row_reg, last_row_next;
    logic [LMW-1:0]      pbit_reg, pbit_next;
    logic [ESW-1:0]      eff_reg, eff_next;
    logic [RAW-1:0]      rd_row_reg, rd_row_next;
    logic [OAW-1:0]      own_addr_reg, own_addr_next;
    logic                out_valid_reg, out_valid_next;

    // payload
    logic [HANDLE_W-1:0]   handle_reg, handle_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [ID_W-1:0]       assigned_reg, assigned_next;
    logic [HANDLE_W-1:0]   freed_reg, freed_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [MW-1:0]         mark_rdata_reg;
    logic [HANDLE_W-1:0]   own_rdata_reg;

    // memory write controls
    logic                mark_we;
    logic [RAW-1:0]      mark_waddr;
    logic [MW-1:0]       mark_wdata;
    logic                own_we;
    logic [OAW-1:0]      own_waddr;

    // effective sizes
    logic [ESW-1:0]      eff0, eff1;

    // accept-side decode
    logic                in_op, a_pool, f_pool, f_range;
    logic [HANDLE_W-1:0] in_handle;
    logic [ID_W-1:0]     f_id, f_off;
    logic [ESW-1:0]      a_eff, f_eff, a_eff_m1;
    logic [SW-1:0]       a_pos, a_start, f_slot;

    // shared find-first unit
    logic [MW-1:0]       free_mask;
    logic                hit;
    logic [LMW-1:0]      hit_bit;
    logic [SW-1:0]       hit_idx;
    logic [LMW-1:0]      free_bit;

    function automatic logic [RAW-1:0] row_addr(input logic pool, input logic [RW-1:0] row);
        return pool ? (RAW'(RPP) + RAW'(row)) : RAW'(row);
    endfunction

    function automatic logic [OAW-1:0] cell_addr(input logic pool, input logic [SW-1:0] slot);
        return pool ? (OAW'(S) + OAW'(slot)) : OAW'(slot);
    endfunction

    // size registers above the slot count act as the slot count
    assign eff0 = (32'(pool0_size_reg) > 32'(S)) ? ESW'(S) : ESW'(pool0_size_reg);
    assign eff1 = (32'(pool1_size_reg) > 32'(S)) ? ESW'(S) : ESW'(pool1_size_reg);

    assign in_op     = s_axis_tuser[0];
    assign a_pool    = s_axis_tdata[0];
    assign in_handle = s_axis_tdata[32:1];
    assign f_id      = s_axis_tdata[48:33];

    assign a_eff    = a_pool ? eff1 : eff0;
    assign a_eff_m1 = a_eff - ESW'(1);
    assign a_pos    = scan_pos_reg[a_pool];
    // restart at slot zero when the position lies beyond the size
    assign a_start  = (32'(a_pos) >= 32'(a_eff)) ? '0 : a_pos;

    assign f_pool  = (f_id >= pool1_base_reg);
    assign f_off   = f_pool ? (f_id - pool1_base_reg) : f_id;
    assign f_eff   = f_pool ? eff1 : eff0;
    assign f_range = (f_id == RELEASE_ID_NONE) || (32'(f_off) >= 32'(f_eff));
    assign f_slot  = SW'(f_off);

    // Mask the row to free slots inside the pool size and on the proper side of
    // the start position: at or above it on the first pass, below it after wrap.
    always_comb
    begin
        for (int b = 0; b < MW; b++)
        begin
            free_mask[b] = ~mark_rdata_reg[b]
                && (32'({row_reg, LMW'(b)}) < 32'(eff_reg))
                && ((row_reg != row0_reg)
                    || (wrapped_reg ? (LMW'(b) < pbit_reg) : (LMW'(b) >= pbit_reg)));
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_bit = '0;
        for (int b = MW - 1; b >= 0; b--)
        begin
            if (free_mask[b])
            begin
                hit     = 1'b1;
                hit_bit = LMW'(b);
            end
        end
    end

    assign hit_idx  = SW'({row_reg, hit_bit});
    assign free_bit = LMW'(slot_reg);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_row_next    = clr_row_reg;
        pool0_size_next = pool0_size_reg;
        pool1_size_next = pool1_size_reg;
        pool1_base_next = pool1_base_reg;
        count_next      = count_reg;
        scan_pos_next   = scan_pos_reg;
        pool_next       = pool_reg;
        wrapped_next    = wrapped_reg;
        row_next        = row_reg;
        row0_next       = row0_reg;
        last_row_next   = last_row_reg;
        pbit_next       = pbit_reg;
        eff_next        = eff_reg;
        rd_row_next     = rd_row_reg;
        own_addr_next   = own_addr_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        handle_next     = handle_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        assigned_next   = assigned_reg;
        freed_next      = freed_reg;
        out_data_next   = out_data_reg;
        mark_we         = 1'b0;
        mark_waddr      = rd_row_reg;
        mark_wdata      = mark_rdata_reg;
        own_we          = 1'b0;
        own_waddr       = cell_addr(pool_reg, hit_idx);

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POOL0_SIZE: pool0_size_next = cfg_data[SIZE_W-1:0];
                CFG_POOL1_SIZE: pool1_size_next = cfg_data[SIZE_W-1:0];
                CFG_POOL1_BASE: pool1_base_next = cfg_data[BASE_W-1:0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mark_we    = 1'b1;
                mark_waddr = clr_row_reg;
                mark_wdata = '0;
                clr_row_next = clr_row_reg + RAW'(1);
                if (clr_row_reg == RAW'(ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    assigned_next = '0;
                    freed_next    = '0;
                    if (in_op == OP_ALLOC)
                    begin
                        pool_next = a_pool;
                        if (count_reg[a_pool] >= a_eff)
                        begin
                            status_next = STATUS_FULL;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            handle_next   = in_handle;
                            eff_next      = a_eff;
                            row0_next     = RW'(a_start >> LMW);
                            row_next      = RW'(a_start >> LMW);
                            pbit_next     = LMW'(a_start);
                            last_row_next = RW'(a_eff_m1 >> LMW);
                            wrapped_next  = 1'b0;
                            rd_row_next   = row_addr(a_pool, RW'(a_start >> LMW));
                            state_next    = ST_SCAN_WAIT;
                        end
                    end
                    else
                    begin
                        pool_next = f_pool;
                        if (f_range)
                        begin
                            status_next = STATUS_RANGE;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            slot_next     = f_slot;
                            rd_row_next   = row_addr(f_pool, RW'(f_slot >> LMW));
                            own_addr_next = cell_addr(f_pool, f_slot);
                            state_next    = ST_FREE_WAIT;
                        end
                    end
                end
            end

            ST_SCAN_WAIT:
            begin
                state_next = ST_SCAN_CHK;
            end

            ST_SCAN_CHK:
            begin
                if (hit)
                begin
                    // claim the slot, remember it as the next-fit position
                    mark_we    = 1'b1;
                    mark_wdata = mark_rdata_reg | (MW'(1) << hit_bit);
                    own_we     = 1'b1;
                    count_next[pool_reg]    = count_reg[pool_reg] + ESW'(1);
                    scan_pos_next[pool_reg] = hit_idx;
                    assigned_next = pool_reg ? (ID_W'(hit_idx) + pool1_base_reg)
                                             : ID_W'(hit_idx);
                    status_next   = STATUS_OK;
                    state_next    = ST_FINISH;
                end
                else if (wrapped_reg && (row_reg == row0_reg))
                begin
                    status_next = STATUS_FULL;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    if (!wrapped_reg && (row_reg == last_row_reg))
                    begin
                        row_next     = '0;
                        wrapped_next = 1'b1;
                        rd_row_next  = row_addr(pool_reg, '0);
                    end
                    else
                    begin
                        row_next    = row_reg + RW'(1);
                        rd_row_next = row_addr(pool_reg, row_reg + RW'(1));
                    end
                    state_next = ST_SCAN_WAIT;
                end
            end

            ST_FREE_WAIT:
            begin
                state_next = ST_FREE_CHK;
            end

            ST_FREE_CHK:
            begin
                if (!mark_rdata_reg[free_bit])
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    mark_we     = 1'b1;
                    mark_wdata  = mark_rdata_reg & ~(MW'(1) << free_bit);
                    freed_next  = own_rdata_reg;
                    status_next = STATUS_OK;
                    if (count_reg[pool_reg] != '0)
                    begin
                        count_next[pool_reg] = count_reg[pool_reg] - ESW'(1);
                    end
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'b0, COUNT_OUT_W'(count_reg[pool_reg]), freed_reg,
                                      assigned_reg, status_reg};
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_row_reg    <= '0;
            pool0_size_reg <= SIZE_RESET;
            pool1_size_reg <= SIZE_RESET;
            pool1_base_reg <= BASE_RESET;
            for (int p = 0; p < POOLS; p++)
            begin
                count_reg[p]    <= '0;
                scan_pos_reg[p] <= '0;
            end
            pool_reg       <= 1'b0;
            wrapped_reg    <= 1'b0;
            row_reg        <= '0;
            row0_reg       <= '0;
            last_row_reg   <= '0;
            pbit_reg       <= '0;
            eff_reg        <= '0;
            rd_row_reg     <= '0;
            own_addr_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_row_reg    <= clr_row_next;
            pool0_size_reg <= pool0_size_next;
            pool1_size_reg <= pool1_size_next;
            pool1_base_reg <= pool1_base_next;
            count_reg      <= count_next;
            scan_pos_reg   <= scan_pos_next;
            pool_reg       <= pool_next;
            wrapped_reg    <= wrapped_next;
            row_reg        <= row_next;
            row0_reg       <= row0_next;
            last_row_reg   <= last_row_next;
            pbit_reg       <= pbit_next;
            eff_reg        <= eff_next;
            rd_row_reg     <= rd_row_next;
            own_addr_reg   <= own_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        handle_reg   <= handle_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        assigned_reg <= assigned_next;
        freed_reg    <= freed_next;
        out_data_reg <= out_data_next;
    end

    // mark memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rdata_reg <= mark_mem[rd_row_reg];
    end

    // owner handle memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            owner_mem[own_waddr] <= handle_reg;
        end
        own_rdata_reg <= owner_mem[own_addr_reg];
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: bench/id_allocator_checker.sv
// Result checker for the two-pool next-fit ID allocator.
// Watches the config port and both streams, predicts each result word, compares it.
// Depends on tpida_pkg only.
`timescale 1ns / 100ps

module id_allocator_checker (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_we,
    input  wire  [tpida_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [tpida_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire                               s_tvalid,
    input  wire                               s_tready,
    input  wire  [tpida_pkg::IN_DATA_W-1:0]   s_tdata,
    input  wire  [0:0]                        s_tuser,
    input  wire                               m_tvalid,
    input  wire                               m_tready,
    input  wire  [tpida_pkg::OUT_DATA_W-1:0]  m_tdata,
    output int                                fail_count,
    output int                                outstanding,
    output int                                words_checked,
    output logic [3:0]                        status_seen
);
    import tpida_pkg::*;

    localparam int SLOTS = SLOTS_PER_POOL_DEF;

    // high field first, so the cast from the bus keeps the bit order
    typedef struct packed {
        logic                opcode;
        logic [ID_W-1:0]     release_id;
        logic [HANDLE_W-1:0] owner_handle;
        logic                pool_select;
    } request_t;

    typedef struct packed {
        logic [COUNT_OUT_W-1:0] pool_count;
        logic [HANDLE_W-1:0]    freed_handle;
        logic [ID_W-1:0]        assigned_id;
        logic [STATUS_W-1:0]    status;
    } outcome_t;

    logic                   occupied [POOLS][SLOTS];
    logic [HANDLE_W-1:0]    owner_of [POOLS][SLOTS];
    logic [COUNT_OUT_W-1:0] held     [POOLS];
    int unsigned            cursor   [POOLS];
    logic [SIZE_W-1:0]      size_reg [POOLS];
    logic [BASE_W-1:0]      pool1_base;
    outcome_t               awaited_results [$];

    function automatic int unsigned usable_slots(int unsigned pool);
        return (size_reg[pool] > SLOTS) ? SLOTS : size_reg[pool];
    endfunction

    function automatic outcome_t serve_request(request_t rq);
        outcome_t          res;
        int unsigned       pool;
        int unsigned       lim;
        int unsigned       start;
        int unsigned       idx;
        int unsigned       k;
        logic              found;
        logic [BASE_W-1:0] base;
        logic [ID_W-1:0]   offset;
        res = '0;
        found = 1'b0;
        if (rq.opcode == OP_ALLOC)
        begin
            pool = rq.pool_select;
            lim = usable_slots(pool);
            base = (pool == 1) ? pool1_base : '0;
            res.status = STATUS_FULL;
            if (held[pool] < lim)
            begin
                // next fit: resume at the last slot taken, wrap at the pool size
                start = (cursor[pool] >= lim) ? 0 : cursor[pool];
                for (k = 0; k < lim && !found; k++)
                begin
                    idx = start + k;
                    if (idx >= lim)
                        idx -= lim;
                    if (!occupied[pool][idx])
                    begin
                        found = 1'b1;
                        occupied[pool][idx] = 1'b1;
                        owner_of[pool][idx] = rq.owner_handle;
                        held[pool] = held[pool] + 1'b1;
                        cursor[pool] = idx;
                        res.assigned_id = ID_W'(idx + base);
                        res.status = STATUS_OK;
                    end
                end
            end
        end
        else
        begin
            pool = (rq.release_id >= pool1_base) ? 1 : 0;
            base = (pool == 1) ? pool1_base : '0;
            offset = rq.release_id - base;
            if (rq.release_id == RELEASE_ID_NONE || offset >= usable_slots(pool))
                res.status = STATUS_RANGE;
            else if (!occupied[pool][offset])
                res.status = STATUS_EMPTY;
            else
            begin
                res.freed_handle = owner_of[pool][offset];
                occupied[pool][offset] = 1'b0;
                owner_of[pool][offset] = '0;
                if (held[pool] != 0)
                    held[pool] = held[pool] - 1'b1;
            end
        end
        res.pool_count = held[pool];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [HANDLE_W-1:0] want,
                               input logic [HANDLE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            for (int p = 0; p < POOLS; p++)
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    occupied[p][s] = 1'b0;
                    owner_of[p][s] = '0;
                end
                held[p] = '0;
                cursor[p] = 0;
                size_reg[p] = SIZE_RESET;
            end
            pool1_base = BASE_RESET;
            awaited_results.delete();
            fail_count = 0;
            words_checked = 0;
            status_seen = '0;
            outstanding <= 0;
        end
        else
        begin
            // the result leaving now always belongs to an earlier word, so retire it first
            if (m_tvalid && m_tready)
            begin
                got = outcome_t'(m_tdata[$bits(outcome_t)-1:0]);
                if (awaited_results.size() == 0)
                begin
                    $error("result word %0h arrived with nothing outstanding", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("assigned_id", want.assigned_id, got.assigned_id);
                    check_field("freed_handle", want.freed_handle, got.freed_handle);
                    check_field("pool_count", want.pool_count, got.pool_count);
                    check_field("zero fill", '0, m_tdata[OUT_DATA_W-1:$bits(outcome_t)]);
                    status_seen[got.status] = 1'b1;
                    words_checked++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POOL0_SIZE: size_reg[0] = cfg_data[SIZE_W-1:0];
                    CFG_POOL1_SIZE: size_reg[1] = cfg_data[SIZE_W-1:0];
                    CFG_POOL1_BASE: pool1_base = cfg_data[BASE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(
                    serve_request(request_t'({s_tuser[0], s_tdata[$bits(request_t)-2:0]})));
            outstanding <= awaited_results.size();
        end
    end

endmodule

// File: bench/two_pool_next_fit_id_allocator_top_test.sv
// Top-level testbench for the two-pool next-fit ID allocator.
// Makes stimulus and config writes, gives the verdict; checking lives in id_allocator_checker.
// Depends on tpida_pkg, id_allocator_checker and the allocator RTL.
`timescale 1ns / 100ps

module two_pool_next_fit_id_allocator_top_test;
    import tpida_pkg::*;

    localparam int SLOTS = SLOTS_PER_POOL_DEF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    // tdata from bit 0: pool_select, owner_handle, release_id, zero fill
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    // tuser: opcode
    logic [0:0]            s_tuser = '0;
    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    // tdata from bit 0: status, assigned_id, freed_handle, pool_count, zero fill
    wire [OUT_DATA_W-1:0]  m_tdata;

    int         fail_count;
    int         outstanding;
    int         words_checked;
    logic [3:0] status_seen;

    // percentage of cycles in which each side holds off
    int send_idle_pct = 10;
    int recv_idle_pct = 69;

    // stimulus-side copy of what was written, used to aim frees at live ranges
    logic [SIZE_W-1:0] cur_size [POOLS] = '{SIZE_RESET, SIZE_RESET};
    logic [BASE_W-1:0] cur_base = BASE_RESET;
    int                settings_used = 0;
    logic [ID_W-1:0]   live_ids [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    two_pool_next_fit_id_allocator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    id_allocator_checker result_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .words_checked (words_checked),
        .status_seen   (status_seen)
    );

    // Receiver: drop ready at random according to the current idling mix.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Harvest IDs handed out by successful allocates so later frees hit used slots.
    // A free also answers ok with a zero ID; an extra free of ID zero does no harm.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready && m_tdata[STATUS_W-1:0] == STATUS_OK
            && m_tdata[STATUS_W+ID_W +: HANDLE_W] == '0)
        begin
            live_ids.push_back(m_tdata[STATUS_W +: ID_W]);
            if (live_ids.size() > 2 * SLOTS)
                void'(live_ids.pop_front());
        end
    end

    // Present one word and hold it until accepted. Valid stays high into the next
    // word unless a gap is drawn, so it never gets two updates in one step.
    task automatic send_word(input logic op, input logic pool,
                             input logic [HANDLE_W-1:0] handle, input logic [ID_W-1:0] id);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'({id, handle, pool});
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop sending and hold until every predicted result has been drained.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_POOL0_SIZE: cur_size[0] = val[SIZE_W-1:0];
            CFG_POOL1_SIZE: cur_size[1] = val[SIZE_W-1:0];
            CFG_POOL1_BASE: cur_base = val[BASE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int size0, input int size1, input int base1);
        write_reg(CFG_POOL0_SIZE, CFG_DATA_W'(size0));
        write_reg(CFG_POOL1_SIZE, CFG_DATA_W'(size1));
        write_reg(CFG_POOL1_BASE, CFG_DATA_W'(base1));
        settings_used++;
    endtask

    // One random word. Frees mostly target harvested IDs or offsets around the
    // pool bounds; the rest are raw IDs and the invalid ID.
    task automatic random_word(input int alloc_pct, input int pool0_pct);
        int unsigned     pick;
        int unsigned     lim;
        int unsigned     k;
        logic            pool;
        logic [ID_W-1:0] id;
        pool = ($urandom_range(99) < pool0_pct) ? 1'b0 : 1'b1;
        id = ID_W'($urandom);
        if ($urandom_range(99) < alloc_pct)
            send_word(OP_ALLOC, pool, $urandom, id);
        else
        begin
            pick = $urandom_range(99);
            lim = (cur_size[pool] > SLOTS) ? SLOTS : cur_size[pool];
            if (pick < 55 && live_ids.size() != 0)
            begin
                k = $urandom_range(live_ids.size() - 1);
                id = live_ids[k];
                live_ids.delete(k);
            end
            else if (pick < 85)
                id = ID_W'((pool ? cur_base : BASE_W'(0)) + $urandom_range(lim + 1));
            else if (pick >= 95)
                id = RELEASE_ID_NONE;
            send_word(OP_FREE, pool, $urandom, id);
        end
    endtask

    task automatic run_burst(input int count, input int alloc_pct, input int pool0_pct);
        for (int i = 0; i < count; i++)
        begin
            random_word(alloc_pct, pool0_pct);
            // now and then hold the sender until the block has fully drained
            if ($urandom_range(99) == 0)
                drain();
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        drain();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: two slots in pool zero, one in pool one.
        configure(2, 1, 15000);
        send_word(OP_ALLOC, 1'b0, 32'h0000_0000, 16'hFFFF);
        send_word(OP_ALLOC, 1'b0, 32'hFFFF_FFFF, 16'h0000);
        send_word(OP_ALLOC, 1'b0, 32'h1234_5678, 16'h0000);  // pool zero full
        send_word(OP_ALLOC, 1'b1, 32'hA5A5_A5A5, 16'h0000);
        send_word(OP_FREE, 1'b1, 32'hFFFF_FFFF, 16'd15000);
        send_word(OP_FREE, 1'b0, 32'h0000_0000, 16'd15000);   // already empty
        send_word(OP_FREE, 1'b0, 32'h0000_0000, 16'd15001);   // offset equals size
        send_word(OP_FREE, 1'b1, 32'h0000_0000, RELEASE_ID_NONE);
        send_word(OP_FREE, 1'b0, 32'h0000_0000, 16'd2);
        send_word(OP_FREE, 1'b0, 32'h0000_0000, 16'd0);
        send_word(OP_ALLOC, 1'b0, 32'h5A5A_5A5A, 16'h0000);  // scan wraps to slot zero

        // Shrink pool zero below its occupancy: slot one is stranded.
        write_reg(CFG_POOL0_SIZE, CFG_DATA_W'(1));
        send_word(OP_ALLOC, 1'b0, 32'h0F0F_0F0F, 16'h0000);
        send_word(OP_FREE, 1'b0, 32'h0000_0000, 16'd1);
        send_word(OP_FREE, 1'b0, 32'h0000_0000, 16'd0);
        send_word(OP_ALLOC, 1'b0, 32'hF0F0_F0F0, 16'h0000);

        // Zero-size pool zero, then base zero so every ID maps to pool one.
        write_reg(CFG_POOL0_SIZE, CFG_DATA_W'(0));
        send_word(OP_ALLOC, 1'b0, 32'h1111_1111, 16'h0000);
        send_word(OP_FREE, 1'b0, 32'h0000_0000, 16'd0);
        configure(0, 511, 0);
        send_word(OP_FREE, 1'b0, 32'h0000_0000, 16'd0);
        send_word(OP_ALLOC, 1'b1, 32'h8000_0001, 16'h0000);
        send_word(OP_FREE, 1'b1, 32'h0000_0000, 16'd0);
        send_word(OP_FREE, 1'b1, 32'h0000_0000, 16'hFFFE);

        // Highest base: the last ID before it falls to pool zero and out of range.
        configure(256, 256, 65279);
        send_word(OP_ALLOC, 1'b1, 32'h7FFF_FFFE, 16'h0000);
        send_word(OP_FREE, 1'b1, 32'h0000_0000, 16'd65279);
        send_word(OP_FREE, 1'b0, 32'h0000_0000, 16'd65278);
        send_word(OP_ALLOC, 1'b0, 32'hC3C3_C3C3, 16'h0000);

        // Random, first mix: sender rarely idle, receiver mostly stalled.
        configure(4, 7, 300);
        run_burst(175, 50, 50);
        configure(0, 3, 0);
        run_burst(175, 50, 50);

        // Second mix: roles swapped.
        set_idling(69, 10);
        configure(1, 511, 65279);
        run_burst(175, 55, 50);
        configure(16, 16, 40000);
        run_burst(175, 50, 50);

        // Third mix: full rate both ways; fill pool zero past its clamp.
        set_idling(0, 0);
        configure(511, 256, 15000);
        run_burst(200, 85, 80);
        configure(256, 1, 1);
        run_burst(150, 50, 50);

        drain();
        repeat (30) @(posedge clk);
        $display("Checked %0d result words across %0d register settings and three idling mixes.",
                 words_checked, settings_used);
        $display("Status codes returned (one bit per code, ok in bit 0): %b", status_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
design/tpida_pkg.sv
design/two_pool_next_fit_id_allocator_top.sv
bench/id_allocator_checker.sv
bench/two_pool_next_fit_id_allocator_top_test.sv
